// File: rtl/mcg_pkg.sv
package mcg_pkg;

  // Status bytes and kinds
  localparam logic [7:0] ST_TIMING_CLOCK = 8'hF8;
  localparam logic [7:0] ST_SYSTEM       = 8'hF0;
  localparam logic [3:0] KIND_NOTE_OFF   = 4'h8;
  localparam logic [3:0] KIND_NOTE_ON    = 4'h9;
  localparam logic [3:0] KIND_CTRL       = 4'hB;
  localparam logic [3:0] KIND_BEND       = 4'hE;
  localparam logic [3:0] CHAN_FIRST      = 4'h0;

  localparam logic [6:0] CTRL_MOD        = 7'd4;
  localparam logic [7:0] NO_NOTE         = 8'd255;
  localparam logic [13:0] BEND_CENTER    = 14'd8192;
  localparam logic [7:0] MIDDLE_C        = 8'd60;
  localparam logic [10:0] MOD_OFFSET     = 11'd762;

  // Highest inputs_in_use value at which each output is still driven
  localparam logic [2:0] PITCH_MAX_USE   = 3'd2;
  localparam logic [2:0] MOD_MAX_USE     = 3'd3;
  localparam logic [2:0] GATE_MAX_USE    = 3'd4;
  localparam logic [2:0] PULSE_MAX_USE   = 3'd5;

  localparam logic [7:0] DEFAULT_PULSE_TICKS = 8'd10;

  // Configuration register indexes
  localparam logic CFG_INPUTS_IN_USE = 1'b0;
  localparam logic CFG_PULSE_TICKS   = 1'b1;

  // Input item command codes
  localparam logic CMD_MESSAGE = 1'b0;
  localparam logic CMD_TICK    = 1'b1;

  typedef struct packed {
    logic       command;
    logic [7:0] status_byte;
    logic [6:0] data_first;
    logic [6:0] data_second;
  } in_item_t;

  typedef struct packed {
    logic signed [20:0] pitch_cv;
    logic signed [10:0] mod_cv;
    logic               note_gate;
    logic               clock_pulse;
  } out_item_t;

  typedef struct packed {
    logic [2:0] inputs_in_use;
    logic [7:0] clock_pulse_ticks;
  } cfg_t;

endpackage

// File: rtl/mcg_in_reg.sv
module mcg_in_reg (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  mcg_pkg::in_item_t in_data,
  input  logic              take,
  output logic              item_valid,
  output mcg_pkg::in_item_t item
);
  import mcg_pkg::*;

  logic     valid_r, valid_nxt;
  in_item_t item_r;

  // Stage is free when empty or when its item moves on this cycle
  assign in_ready  = !valid_r || take;
  assign valid_nxt = in_valid || (valid_r && !take);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Load payload on each accepted transaction
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_data;
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

// File: rtl/mcg_core.sv
module mcg_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               item_valid,
  input  mcg_pkg::in_item_t  item,
  input  mcg_pkg::cfg_t      cfg,
  output logic               take,
  output logic               out_valid,
  input  logic               out_ready,
  output mcg_pkg::out_item_t out_data
);
  import mcg_pkg::*;

  logic [7:0]  held_note_r, held_note_nxt;
  logic [13:0] bend_r, bend_nxt;
  logic [7:0]  countdown_r, countdown_nxt;
  out_item_t   level_r, level_nxt;
  logic        out_valid_r, out_valid_nxt;

  logic [3:0]         kind;
  logic [3:0]         chan;
  logic               dropped;
  logic               is_note_on;
  logic               is_note_off;
  logic [7:0]         pitch_note;
  logic [13:0]        pitch_bend;
  logic signed [7:0]  note_diff;
  logic signed [13:0] bend_diff;
  logic signed [20:0] pitch_value;
  logic [10:0]        mod_scaled;

  // Advance when the result register is empty or being drained
  assign take          = item_valid && (!out_valid_r || out_ready);
  assign out_valid_nxt = take || (out_valid_r && !out_ready);

  assign kind        = item.status_byte[7:4];
  assign chan        = item.status_byte[3:0];
  assign dropped     = (chan != CHAN_FIRST) && (item.status_byte < ST_SYSTEM);
  assign is_note_on  = (kind == KIND_NOTE_ON) && (item.data_second != 7'd0);
  assign is_note_off = (kind == KIND_NOTE_OFF) ||
                       ((kind == KIND_NOTE_ON) && (item.data_second == 7'd0));

  // Pitch uses the new note on note-on, the new bend on bend
  assign pitch_note  = is_note_on ? {1'b0, item.data_first} : held_note_r;
  assign pitch_bend  = (kind == KIND_BEND) ? {item.data_second, item.data_first} : bend_r;
  assign note_diff   = $signed(pitch_note - MIDDLE_C);
  assign bend_diff   = $signed(pitch_bend - BEND_CENTER);
  assign pitch_value = $signed({note_diff, 13'd0})
                     + 21'($signed({bend_diff, 1'b0}));
  assign mod_scaled  = 11'({4'd0, item.data_second} * 11'd12) - MOD_OFFSET;

  // Next state for one item
  always_comb begin
    held_note_nxt = held_note_r;
    bend_nxt      = bend_r;
    countdown_nxt = countdown_r;
    level_nxt     = level_r;
    if (item.command == CMD_TICK) begin
      if (countdown_r != 8'd0) begin
        countdown_nxt = countdown_r - 8'd1;
        if (countdown_r == 8'd1) begin
          level_nxt.clock_pulse = 1'b0;
        end
      end
    end else if (!dropped) begin
      if (item.status_byte == ST_TIMING_CLOCK) begin
        if (cfg.inputs_in_use <= PULSE_MAX_USE) begin
          level_nxt.clock_pulse = 1'b1;
          countdown_nxt         = cfg.clock_pulse_ticks;
        end
      end else if (is_note_on) begin
        held_note_nxt = {1'b0, item.data_first};
        if (cfg.inputs_in_use <= PITCH_MAX_USE) begin
          level_nxt.pitch_cv = pitch_value;
        end
        if (cfg.inputs_in_use <= GATE_MAX_USE) begin
          level_nxt.note_gate = 1'b1;
        end
      end else if (is_note_off) begin
        if (({1'b0, item.data_first} == held_note_r) &&
            (cfg.inputs_in_use <= GATE_MAX_USE)) begin
          level_nxt.note_gate = 1'b0;
        end
      end else if (kind == KIND_BEND) begin
        bend_nxt = pitch_bend;
        if ((cfg.inputs_in_use <= PITCH_MAX_USE) && (held_note_r != NO_NOTE)) begin
          level_nxt.pitch_cv = pitch_value;
        end
      end else if (kind == KIND_CTRL) begin
        if ((item.data_first == CTRL_MOD) && (cfg.inputs_in_use <= MOD_MAX_USE)) begin
          level_nxt.mod_cv = $signed(mod_scaled);
        end
      end
    end
  end

  // Commit state and result on each advance
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_note_r <= NO_NOTE;
      bend_r      <= BEND_CENTER;
      countdown_r <= 8'd0;
      level_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (take) begin
        held_note_r <= held_note_nxt;
        bend_r      <= bend_nxt;
        countdown_r <= countdown_nxt;
        level_r     <= level_nxt;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = level_r;

endmodule

// File: rtl/midi_to_cv_gate_converter.sv
// Channel  Direction  Handshake              Payload
// in_      input      in_valid / in_ready    in_data   (in_item_t)
// out_     output     out_valid / out_ready  out_data  (out_item_t)
// cfg_     input      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One result per item; an accepted item passes the input register, then
// the state update into the result register, before its result shows
// on out_data. Sustained rate is one item per cycle while out_ready is
// high; the held note, bend and pulse countdown update in one step
// between the two registers.
// Synchronous active-low reset restores the power-up levels and config.
// A stall on out_ready holds the result and backs up the input stage.
module midi_to_cv_gate_converter (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  mcg_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output mcg_pkg::out_item_t out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_index,
  input  logic [7:0]         cfg_data
);
  import mcg_pkg::*;

  cfg_t     cfg_r;
  logic     item_valid;
  in_item_t item;
  logic     take;

  assign cfg_ready = 1'b1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.inputs_in_use     <= 3'd0;
      cfg_r.clock_pulse_ticks <= DEFAULT_PULSE_TICKS;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_INPUTS_IN_USE: cfg_r.inputs_in_use     <= cfg_data[2:0];
        CFG_PULSE_TICKS:   cfg_r.clock_pulse_ticks <= cfg_data;
        default: ;
      endcase
    end
  end

  mcg_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .take       (take),
    .item_valid (item_valid),
    .item       (item)
  );

  mcg_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (item_valid),
    .item       (item),
    .cfg        (cfg_r),
    .take       (take),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

  // Empty input stage always takes a transaction
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !item_valid |-> in_ready)
    else $error("input stage empty but not ready");

  // Accepted transaction lands in the input stage
  a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> item_valid)
    else $error("accepted transaction lost");

  // Advanced item produces a result
  a_take_result: assert property (@(posedge clk) disable iff (!rst_n)
    take |=> out_valid)
    else $error("advanced item gave no result");

  // Stalled item holds in the input stage
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    item_valid && !take |=> item_valid && $stable(item))
    else $error("stalled item changed");

endmodule
